// ===== hdl/spv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spv_pkg
// Shared types, constants and helpers of the sample playback voice.
// ----------------------------------------------------------------------------
package spv_pkg;

    localparam int SAMPLE_DEPTH = 65536;
    localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);

    localparam logic [23:0] DECAY_RESET   = 24'd16609444;
    localparam logic [23:0] COSINE_RESET  = 24'd4194304;
    localparam logic [14:0] TREBLE_RESET  = 15'h7000;
    localparam logic [19:0] SILENCE_RESET = 20'd105;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_NOTE_ON = 2'd1,
        OP_RELEASE = 2'd2,
        OP_RENDER  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_TREBLE_GAIN = 3'd0,
        CFG_TREBLE_COEF = 3'd1,
        CFG_LFO_STEP    = 3'd2,
        CFG_LEFT_DEPTH  = 3'd3,
        CFG_RIGHT_DEPTH = 3'd4,
        CFG_DRIVE       = 3'd5,
        CFG_SILENCE     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_op                op;
        logic        [15:0] address;
        logic signed [15:0] sample_word;
        logic        [23:0] pitch_step;
        logic        [15:0] loop_end;
        logic        [15:0] loop_length;
        logic        [23:0] start_level;
        logic        [23:0] decay_factor;
        logic signed [15:0] gain_left;
        logic signed [15:0] gain_right;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] left_out;
        logic signed [23:0] right_out;
        logic               voice_active;
    } t_out_item;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PHASE,
        ST_RD0,
        ST_RD1,
        ST_MUL_INTERP,
        ST_INTERP,
        ST_X,
        ST_SINE,
        ST_XX,
        ST_COS,
        ST_DRIVE,
        ST_TREM_L,
        ST_TREM_R,
        ST_PAN_L,
        ST_PAN_R,
        ST_LOW_L,
        ST_LOW_R,
        ST_TREB_L,
        ST_TREB_R,
        ST_MOD_L,
        ST_MOD_R,
        ST_FINISH,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic   accept;
        logic   emit;
        t_state step;
    } t_cmd;

    typedef struct packed {
        logic voice_on;
        logic out_free;
    } t_stat;

    function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
        if (v > 40'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -40'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    // position to memory index, modulo the memory depth
    function automatic logic [ADDR_W-1:0] mem_idx(input logic [16:0] v);
        logic [20:0] w;
        w = 21'(v);
        return w[ADDR_W-1:0];
    endfunction

endpackage

// ===== hdl/spv_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spv_ctrl
// Sequencer of the render steps around the shared multiplier.
// ----------------------------------------------------------------------------
module spv_ctrl import spv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_op   i_op,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = (r_state == ST_IDLE);
        o_cmd.accept = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.emit   = (r_state == ST_OUT) && i_stat.out_free;
        o_cmd.step   = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_op == OP_RENDER && i_stat.voice_on) begin
                    n_state = ST_PHASE;
                end
            end
            ST_PHASE:      n_state = ST_RD0;
            ST_RD0:        n_state = ST_RD1;
            ST_RD1:        n_state = ST_MUL_INTERP;
            ST_MUL_INTERP: n_state = ST_INTERP;
            ST_INTERP:     n_state = ST_X;
            ST_X:          n_state = ST_SINE;
            ST_SINE:       n_state = ST_XX;
            ST_XX:         n_state = ST_COS;
            ST_COS:        n_state = ST_DRIVE;
            ST_DRIVE:      n_state = ST_TREM_L;
            ST_TREM_L:     n_state = ST_TREM_R;
            ST_TREM_R:     n_state = ST_PAN_L;
            ST_PAN_L:      n_state = ST_PAN_R;
            ST_PAN_R:      n_state = ST_LOW_L;
            ST_LOW_L:      n_state = ST_LOW_R;
            ST_LOW_R:      n_state = ST_TREB_L;
            ST_TREB_L:     n_state = ST_TREB_R;
            ST_TREB_R:     n_state = ST_MOD_L;
            ST_MOD_L:      n_state = ST_MOD_R;
            ST_MOD_R:      n_state = ST_FINISH;
            ST_FINISH:     n_state = ST_OUT;
            ST_OUT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:       n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/spv_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spv_dp
// Voice state, sample memory, shared multiplier and output register.
// ----------------------------------------------------------------------------
module spv_dp import spv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_in_item    i_in_data,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_index,
    input  logic [20:0] i_cfg_data,
    input  logic        i_out_ready,
    output t_stat       o_stat,
    output logic        o_out_valid,
    output t_out_item   o_out_data
);

    // configuration
    logic signed [14:0] r_treble_gain;
    logic        [15:0] r_treble_coef;
    logic        [20:0] r_lfo_step;
    logic signed [15:0] r_depth_l, r_depth_r;
    logic        [14:0] r_drive;
    logic        [19:0] r_silence;

    // voice state
    logic        [15:0] r_pos, r_frac, r_end, r_loop;
    logic        [23:0] r_step, r_level, r_decay;
    logic signed [15:0] r_pan_l, r_pan_r;
    logic signed [23:0] r_low_l, r_low_r, r_sine, r_cos;
    logic               r_on;

    // work registers
    logic signed [15:0] r_rd, r_s0;
    logic signed [16:0] r_interp;
    logic signed [25:0] r_x;
    logic        [28:0] r_xx;
    logic signed [17:0] r_tl, r_tr;
    logic signed [35:0] r_v, r_vr;
    logic signed [58:0] r_prod;
    logic               r_out_valid;
    t_out_item          r_out;

    logic signed [15:0] mem [SAMPLE_DEPTH];

    logic signed [32:0] mul_a;
    logic signed [25:0] mul_b;
    logic [ADDR_W-1:0]  rd_idx;
    logic [24:0]        acc;
    logic [17:0]        pos_adv;
    logic signed [31:0] x_drv, x_floor;
    logic               active;

    assign o_stat.voice_on = r_on;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;
    assign active          = !({4'd0, r_silence} > r_level);

    // phase advance and loop wrap
    always_comb begin
        acc     = {9'd0, r_frac} + {1'b0, r_step};
        pos_adv = {2'd0, r_pos} + {9'd0, acc[24:16]};
        if (pos_adv > {2'd0, r_end}) begin
            pos_adv = pos_adv - {2'd0, r_loop};
        end
    end

    // one-sided overdrive, clamped at minus the new envelope
    always_comb begin
        x_floor = -signed'({8'd0, r_level});
        x_drv   = 32'(r_x) - 32'(r_prod >>> 14);
        if (x_drv < x_floor) begin
            x_drv = x_floor;
        end
    end

    always_comb begin
        rd_idx = mem_idx({1'b0, r_pos});
        if (i_cmd.step == ST_RD1) begin
            rd_idx = mem_idx({1'b0, r_pos} + 17'd1);
        end
    end

    // operand select of the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.step)
            ST_MUL_INTERP: begin
                mul_a = 33'(17'(r_rd) - 17'(r_s0));
                mul_b = 26'(signed'({1'b0, r_frac}));
            end
            ST_INTERP: begin
                mul_a = 33'(signed'({1'b0, r_level}));
                mul_b = 26'(signed'({1'b0, r_decay}));
            end
            ST_X: begin
                mul_a = 33'(r_interp);
                mul_b = 26'(signed'({1'b0, r_level}));
            end
            ST_SINE: begin
                mul_a = 33'(r_cos);
                mul_b = 26'(signed'({1'b0, r_lfo_step}));
            end
            ST_XX: begin
                mul_a = 33'(r_x);
                mul_b = r_x;
            end
            ST_COS: begin
                mul_a = 33'(r_sine);
                mul_b = 26'(signed'({1'b0, r_lfo_step}));
            end
            ST_DRIVE: begin
                mul_a = 33'(signed'({1'b0, r_xx}));
                mul_b = 26'(signed'({1'b0, r_drive}));
            end
            ST_TREM_L: begin
                mul_a = 33'(r_cos);
                mul_b = 26'(r_depth_l);
            end
            ST_TREM_R: begin
                mul_a = 33'(r_cos);
                mul_b = 26'(r_depth_r);
            end
            ST_PAN_L: begin
                mul_a = 33'(r_x);
                mul_b = 26'(r_pan_l);
            end
            ST_PAN_R: begin
                mul_a = 33'(r_x);
                mul_b = 26'(r_pan_r);
            end
            ST_LOW_L: begin
                mul_a = 33'(37'(r_v) - 37'(r_low_l));
                mul_b = 26'(signed'({1'b0, r_treble_coef}));
            end
            ST_LOW_R: begin
                mul_a = 33'(37'(r_vr) - 37'(r_low_r));
                mul_b = 26'(signed'({1'b0, r_treble_coef}));
            end
            ST_TREB_L: begin
                mul_a = 33'(37'(r_v) - 37'(r_low_l));
                mul_b = 26'(r_treble_gain);
            end
            ST_TREB_R: begin
                mul_a = 33'(37'(r_vr) - 37'(r_low_r));
                mul_b = 26'(r_treble_gain);
            end
            ST_MOD_L: begin
                mul_a = 33'(r_v);
                mul_b = 26'(r_tl);
            end
            ST_MOD_R: begin
                mul_a = 33'(r_vr);
                mul_b = 26'(r_tr);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sample memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_in_data.op == OP_LOAD) begin
            mem[mem_idx({1'b0, i_in_data.address})] <= i_in_data.sample_word;
        end
        r_rd <= mem[rd_idx];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_treble_gain <= TREBLE_RESET;
            r_treble_coef <= '0;
            r_lfo_step    <= '0;
            r_depth_l     <= '0;
            r_depth_r     <= '0;
            r_drive       <= '0;
            r_silence     <= SILENCE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TREBLE_GAIN: r_treble_gain <= i_cfg_data[14:0];
                CFG_TREBLE_COEF: r_treble_coef <= i_cfg_data[15:0];
                CFG_LFO_STEP:    r_lfo_step    <= i_cfg_data;
                CFG_LEFT_DEPTH:  r_depth_l     <= i_cfg_data[15:0];
                CFG_RIGHT_DEPTH: r_depth_r     <= i_cfg_data[15:0];
                CFG_DRIVE:       r_drive       <= i_cfg_data[14:0];
                CFG_SILENCE:     r_silence     <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // voice state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_frac      <= '0;
            r_step      <= '0;
            r_end       <= '0;
            r_loop      <= '0;
            r_level     <= '0;
            r_decay     <= DECAY_RESET;
            r_pan_l     <= '0;
            r_pan_r     <= '0;
            r_low_l     <= '0;
            r_low_r     <= '0;
            r_sine      <= '0;
            r_cos       <= COSINE_RESET;
            r_on        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.accept && i_in_data.op == OP_NOTE_ON) begin
                r_pos   <= i_in_data.address;
                r_frac  <= '0;
                r_step  <= i_in_data.pitch_step;
                r_end   <= i_in_data.loop_end;
                r_loop  <= i_in_data.loop_length;
                r_level <= i_in_data.start_level;
                r_decay <= i_in_data.decay_factor;
                r_pan_l <= i_in_data.gain_left;
                r_pan_r <= i_in_data.gain_right;
                r_on    <= 1'b1;
            end
            if (i_cmd.accept && i_in_data.op == OP_RELEASE) begin
                r_decay <= i_in_data.decay_factor;
            end
            case (i_cmd.step)
                ST_PHASE: begin
                    r_frac <= acc[15:0];
                    r_pos  <= pos_adv[15:0];
                end
                ST_X:      r_level <= r_prod[47:24];
                ST_XX:     r_sine  <= sat24(40'(r_sine) + 40'(r_prod >>> 24));
                ST_DRIVE:  r_cos   <= sat24(40'(r_cos) - 40'(r_prod >>> 24));
                ST_LOW_R:  r_low_l <= sat24(40'(r_low_l) + 40'(r_prod >>> 16));
                ST_TREB_L: r_low_r <= sat24(40'(r_low_r) + 40'(r_prod >>> 16));
                default: ;
            endcase
            if (i_cmd.emit) begin
                r_on <= active;
            end
        end
    end

    // work registers, consuming the previous product
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_cmd.step)
            ST_RD1:    r_s0     <= r_rd;
            ST_INTERP: r_interp <= 17'(r_s0) + 17'(r_prod >>> 16);
            ST_SINE:   r_x      <= 26'(r_prod >>> 15);
            ST_COS:    r_xx     <= r_prod[48:20];
            ST_TREM_L: begin
                if (r_x > 26'sd0) begin
                    r_x <= 26'(x_drv);
                end
            end
            ST_TREM_R: r_tl     <= 18'(r_prod >>> 22);
            ST_PAN_L:  r_tr     <= 18'(r_prod >>> 22);
            ST_PAN_R:  r_v      <= 36'(r_prod >>> 15);
            ST_LOW_L:  r_vr     <= 36'(r_prod >>> 15);
            ST_TREB_R: r_v      <= r_v + 36'(r_prod >>> 12);
            ST_MOD_L:  r_vr     <= r_vr + 36'(r_prod >>> 12);
            ST_MOD_R:  r_v      <= r_v + 36'(r_prod >>> 15);
            ST_FINISH: r_vr     <= r_vr + 36'(r_prod >>> 15);
            default: ;
        endcase
        if (i_cmd.emit) begin
            r_out.left_out     <= sat24(40'(r_v >>> 1));
            r_out.right_out    <= sat24(40'(r_vr >>> 1));
            r_out.voice_active <= active;
        end
    end

endmodule

// ===== hdl/sample_playback_voice.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_playback_voice
// One wavetable voice with interpolation, envelope, drive, pan, treble
// boost and LFO tremolo, driven by load, note-on, release and render items.
// ----------------------------------------------------------------------------
// load, note-on and release items are taken while idle and give no result.
// a render item of an active voice is offered as a result once its frame is
// done, after any wait for the output side: the frame goes through a
// sequencer around one shared 33x26 signed multiplier, seventeen products in
// a chain, after two reads of the single-port sample memory. a render of an
// inactive voice is taken while idle and gives no result. the result register
// holds a finished frame while the next items are taken in.
module sample_playback_voice import spv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [20:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    // step sequencer
    spv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_data.op),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // voice state, memory and arithmetic
    spv_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (t_cfg_idx'(i_cfg_index)),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== bench/tb_sample_playback_voice.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sample_playback_voice
// Self-checking bench for the sample playback voice. A scoreboard class keeps
// its own bit-accurate copy of the voice state and settings, predicts the
// frame of each render item of an active voice and checks the results in order.
// Directed items come first, then random phrases (sample loads, note-ons,
// render runs, releases) under several settings written while idle, with
// bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_sample_playback_voice;
    import spv_pkg::*;

    // scoreboard: predicts each rendered frame and holds pending frames
    class voice_scoreboard;
        logic signed [15:0] wave [int];
        logic [15:0] pos, frac, end_pos, loop_len;
        logic [23:0] step, level, decay;
        longint pan_l, pan_r, low_l, low_r, sine, cosine;
        bit active;
        longint treb_gain, treb_coef, lfo_rate, depth_l, depth_r, drive, silence;
        t_out_item pending_frames [$];
        int errors;

        function new();
            wave.delete();
            pos = 0; frac = 0; end_pos = 0; loop_len = 0;
            step = 0; level = 0; decay = DECAY_RESET;
            pan_l = 0; pan_r = 0; low_l = 0; low_r = 0;
            sine = 0; cosine = longint'(COSINE_RESET);
            active = 0;
            treb_gain = -4096; treb_coef = 0; lfo_rate = 0;
            depth_l = 0; depth_r = 0; drive = 0; silence = longint'(SILENCE_RESET);
            errors = 0;
        endfunction

        function void write_setting(t_cfg_idx idx, logic [20:0] v);
            case (idx)
                CFG_TREBLE_GAIN: treb_gain = longint'($signed(v[14:0]));
                CFG_TREBLE_COEF: treb_coef = longint'(v[15:0]);
                CFG_LFO_STEP:    lfo_rate = longint'(v);
                CFG_LEFT_DEPTH:  depth_l = longint'($signed(v[15:0]));
                CFG_RIGHT_DEPTH: depth_r = longint'($signed(v[15:0]));
                CFG_DRIVE:       drive = longint'(v[14:0]);
                CFG_SILENCE:     silence = longint'(v[19:0]);
                default: ;
            endcase
        endfunction

        function longint clip24(longint v);
            if (v > 8388607) return 8388607;
            if (v < -8388608) return -8388608;
            return v;
        endfunction

        // one output channel: pan, treble boost, tremolo
        function longint shape_channel(longint x, longint pan, ref longint low, longint depth);
            longint v, t;
            v = (pan * x) >>> 15;
            low = clip24(low + ((treb_coef * (v - low)) >>> 16));
            v = v + ((treb_gain * (v - low)) >>> 12);
            t = (depth * cosine) >>> 22;
            v = v + ((v * t) >>> 15);
            return v;
        endfunction

        function void note_item(t_in_item it);
            longint acc, p, s0, s1, interp, x, l, r;
            t_out_item f;
            case (it.op)
                OP_LOAD: wave[it.address] = it.sample_word;
                OP_NOTE_ON: begin
                    pos = it.address; frac = 0; step = it.pitch_step;
                    end_pos = it.loop_end; loop_len = it.loop_length;
                    level = it.start_level; decay = it.decay_factor;
                    pan_l = longint'(it.gain_left); pan_r = longint'(it.gain_right);
                    active = 1;
                end
                OP_RELEASE: decay = it.decay_factor;
                default: begin
                    if (active) begin
                        acc = longint'(frac) + longint'(step);
                        p = longint'(pos) + (acc >> 16);
                        frac = acc[15:0];
                        if (p > longint'(end_pos)) p = p - longint'(loop_len);
                        pos = p[15:0];
                        s0 = wave.exists(pos) ? longint'(wave[pos]) : 0;
                        s1 = wave.exists(16'(pos + 16'd1)) ?
                             longint'(wave[16'(pos + 16'd1)]) : 0;
                        interp = s0 + ((longint'(frac) * (s1 - s0)) >>> 16);
                        x = (longint'(level) * interp) >>> 15;
                        level = 24'((longint'(level) * longint'(decay)) >> 24);
                        if (x > 0) begin
                            x = x - ((drive * ((x * x) >>> 20)) >>> 14);
                            if (x < -longint'(level)) x = -longint'(level);
                        end
                        sine = clip24(sine + ((lfo_rate * cosine) >>> 24));
                        cosine = clip24(cosine - ((lfo_rate * sine) >>> 24));
                        l = shape_channel(x, pan_l, low_l, depth_l);
                        r = shape_channel(x, pan_r, low_r, depth_r);
                        if (longint'(level) < silence) active = 0;
                        f.left_out = 24'(clip24(l >>> 1));
                        f.right_out = 24'(clip24(r >>> 1));
                        f.voice_active = active;
                        pending_frames.push_back(f);
                    end
                end
            endcase
        endfunction

        function void check_frame(t_out_item got);
            t_out_item exp_f;
            if (pending_frames.size() == 0) begin
                $display("%0t: unexpected frame %h", $time, got);
                errors++;
                return;
            end
            exp_f = pending_frames.pop_front();
            if (got.left_out !== exp_f.left_out) begin
                $display("%0t: left_out expected %0d actual %0d", $time,
                         exp_f.left_out, got.left_out);
                errors++;
            end
            if (got.right_out !== exp_f.right_out) begin
                $display("%0t: right_out expected %0d actual %0d", $time,
                         exp_f.right_out, got.right_out);
                errors++;
            end
            if (got.voice_active !== exp_f.voice_active) begin
                $display("%0t: voice_active expected %0d actual %0d", $time,
                         exp_f.voice_active, got.voice_active);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [20:0] cfg_data;

    voice_scoreboard frames = new();
    int  hold_off_cycles;   // long receiver hold-off, counted below
    bit  stall_pattern_on;
    int  gap_max;           // sender gap bound, varied per phase

    // the memory words written so far, so reads never hit unwritten entries
    bit written [int];

    sample_playback_voice uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // result side: sample at the rising edge, change ready at the falling edge
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            frames.check_frame(out_data);
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            // long hold-off: the block fills up and stalls its input
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end else if (stall_pattern_on) begin
            out_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // one input transfer; valid raised at a falling edge, held until accepted
    task automatic send_item(t_in_item it);
        in_data  = it;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        frames.note_item(it);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // bursts: random-length runs with no gap, then a random gap
    int burst_left;
    task automatic send_paced(t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            repeat (gap) @(negedge clk);
        end
        burst_left--;
        send_item(it);
    endtask

    task automatic write_setting(t_cfg_idx idx, logic [20:0] v);
        cfg_index = idx;
        cfg_data  = v;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        frames.write_setting(idx, v);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // wait until every expected frame has arrived, then let a render that
    // gives no result run out
    task automatic drain();
        while (frames.pending_frames.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    function automatic t_in_item blank_item(t_op op);
        t_in_item it;
        it = '0;
        it.op = op;
        return it;
    endfunction

    task automatic load_word(logic [15:0] a, logic signed [15:0] w);
        t_in_item it;
        it = blank_item(OP_LOAD);
        it.address = a;
        it.sample_word = w;
        it.pitch_step = 24'($urandom());   // unused fields carry noise
        it.gain_left = 16'($urandom());
        written[a] = 1;
        send_paced(it);
    endtask

    // a random note-on whose whole reachable span is already loaded
    function automatic t_in_item random_note(int base, int span);
        t_in_item it;
        int len;
        it = blank_item(OP_NOTE_ON);
        it.address = 16'(base + $urandom_range(0, span / 2));
        it.loop_end = 16'(base + span - 2);
        len = $urandom_range(1, span - 2);
        it.loop_length = 16'(len);
        case ($urandom_range(0, 3))
            0: it.pitch_step = 24'($urandom_range(0, 24'h1FFFF));
            1: it.pitch_step = 24'($urandom_range(0, 24'h8000));
            2: it.pitch_step = 24'(len) << 16 | 24'($urandom_range(0, 16'hFFFF));
            default: it.pitch_step = 24'($urandom_range(0, 24'h3FFFF));
        endcase
        // a frame may advance one position past the whole step, so keep the
        // whole step below the loop length
        if (it.pitch_step[23:16] >= 8'(len)) it.pitch_step[23:16] = 8'(len - 1);
        it.start_level = ($urandom_range(0, 3) == 0) ? 24'($urandom()) :
                         24'($urandom_range(0, 24'h1FFFFF));
        it.decay_factor = ($urandom_range(0, 2) == 0) ? 24'($urandom()) :
                          24'(24'hFFFFFF - $urandom_range(0, 24'h40000));
        it.gain_left = 16'($urandom());
        it.gain_right = 16'($urandom());
        it.sample_word = 16'($urandom());
        return it;
    endfunction

    task automatic render(int n);
        t_in_item it;
        repeat (n) begin
            it = blank_item(OP_RENDER);
            it.address = 16'($urandom());
            it.decay_factor = 24'($urandom());
            send_paced(it);
        end
    endtask

    // load a span at base, play a few notes over it
    task automatic phrase(int base, int span, int notes);
        t_in_item it;
        for (int a = base; a < base + span; a++) begin
            if (!written.exists(a) || $urandom_range(0, 7) == 0) begin
                load_word(16'(a), 16'($urandom()));
            end
        end
        repeat (notes) begin
            send_paced(random_note(base, span));
            render($urandom_range(1, 12));
            if ($urandom_range(0, 2) == 0) begin
                it = blank_item(OP_RELEASE);
                it.decay_factor = 24'($urandom());
                send_paced(it);
                render($urandom_range(0, 6));
            end
        end
    endtask

    task automatic apply_settings(int mode);
        case (mode)
            0: begin
                write_setting(CFG_TREBLE_GAIN, 21'(15'sd12288));
                write_setting(CFG_TREBLE_COEF, 21'd65535);
                write_setting(CFG_LFO_STEP, 21'd1048576);
                write_setting(CFG_LEFT_DEPTH, 21'(16'h7FFF));
                write_setting(CFG_RIGHT_DEPTH, 21'(16'h8000));
                write_setting(CFG_DRIVE, 21'd29491);
                write_setting(CFG_SILENCE, 21'hFFFFF);
            end
            1: begin
                write_setting(CFG_TREBLE_GAIN, 21'(15'h7000));
                write_setting(CFG_TREBLE_COEF, 21'd0);
                write_setting(CFG_LFO_STEP, 21'd0);
                write_setting(CFG_LEFT_DEPTH, 21'(16'h8000));
                write_setting(CFG_RIGHT_DEPTH, 21'(16'h7FFF));
                write_setting(CFG_DRIVE, 21'd0);
                write_setting(CFG_SILENCE, 21'd0);
            end
            default: begin
                write_setting(CFG_TREBLE_GAIN, 21'(15'($urandom_range(0, 16384) - 4096)));
                write_setting(CFG_TREBLE_COEF, 21'($urandom_range(0, 65535)));
                write_setting(CFG_LFO_STEP, 21'($urandom_range(0, 1048576)));
                write_setting(CFG_LEFT_DEPTH, 21'($urandom_range(0, 65535)));
                write_setting(CFG_RIGHT_DEPTH, 21'($urandom_range(0, 65535)));
                write_setting(CFG_DRIVE, 21'($urandom_range(0, 29491)));
                write_setting(CFG_SILENCE, 21'($urandom_range(0, 2000)));
            end
        endcase
    endtask

    // the run ends here if the block hangs
    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_in_item it;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TREBLE_GAIN;
        cfg_data = '0;
        hold_off_cycles = 0;
        stall_pattern_on = 1'b0;
        gap_max = 0;
        burst_left = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: render while inactive, release while inactive
        render(2);
        it = blank_item(OP_RELEASE);
        it.decay_factor = 24'hFFFFFF;
        send_item(it);
        // wrap at the top of memory: position 65535 reads its neighbour at 0
        load_word(16'hFFFF, 16'sh7FFF);
        load_word(16'h0000, -16'sh8000);
        load_word(16'h0001, 16'sh7FFF);
        load_word(16'hFFFE, -16'sh8000);
        load_word(16'h0002, 16'sh1234);
        load_word(16'h0003, -16'sh4321);
        it = blank_item(OP_NOTE_ON);
        it.address = 16'hFFFE;
        it.pitch_step = 24'h008000;
        it.loop_end = 16'hFFFE;
        it.loop_length = 16'hFFFF;
        it.start_level = 24'hFFFFFF;
        it.decay_factor = 24'hFFFFFF;
        it.gain_left = 16'sh7FFF;
        it.gain_right = -16'sh8000;
        send_item(it);
        render(6);
        // note-on below silence still plays one frame, full loop length
        it.start_level = 24'd1;
        it.loop_end = 16'd0;
        it.loop_length = 16'd0;
        it.pitch_step = 24'h01FFFF;
        send_item(it);
        render(2);
        drain();
        apply_settings(0);
        it.start_level = 24'hFFFFFF;
        it.address = 16'h0000;
        it.loop_end = 16'd0;
        it.loop_length = 16'd1;
        it.pitch_step = 24'h010000;
        it.decay_factor = 24'hFFFFFF;
        send_item(it);
        render(4);
        drain();

        // random phrases under varied settings and pacing
        stall_pattern_on = 1'b1;
        for (int phase_no = 0; phase_no < 8; phase_no++) begin
            apply_settings(phase_no == 4 ? 1 : 2);
            gap_max = (phase_no % 3 == 0) ? 0 : $urandom_range(1, 40);
            stall_pattern_on = (phase_no != 2);
            for (int k = 0; k < 4; k++) begin
                if (k == 1 && phase_no == 3) begin
                    hold_off_cycles = 400;
                end
                phrase($urandom_range(0, 3) == 0 ? 16'hFFE0 : 64 * $urandom_range(0, 8),
                       $urandom_range(4, 24), 3);
            end
            drain();   // sender pauses until every frame is back
        end

        drain();
        if (frames.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sample_playback_voice.f =====
hdl/spv_pkg.sv
hdl/spv_ctrl.sv
hdl/spv_dp.sv
hdl/sample_playback_voice.sv
bench/tb_sample_playback_voice.sv
